/* hw/rtl/ira_pkg.sv */
// ----------------------------------------------------------------------------
// ira_pkg: shared definitions for the integer to radix ASCII unit
// Widths, digit encoding constants and the divider result bundle.
// ----------------------------------------------------------------------------
package ira_pkg;

	localparam int VALUE_BITS   = 32;
	localparam int RADIX_W      = 6;
	localparam int CHAR_W       = 7;
	localparam int STEP_BITS    = 4;                        // quotient bits per cycle
	localparam int DIV_CYCLES   = VALUE_BITS / STEP_BITS;
	localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);
	localparam int MAX_DIGITS   = VALUE_BITS;               // base 2 worst case
	localparam int DIGIT_IDX_W  = $clog2(MAX_DIGITS);
	localparam int DIGIT_CNT_W  = $clog2(MAX_DIGITS + 1);

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;     // '0'
	localparam logic [CHAR_W-1:0]  ALPHA_GAP   = 7'd7;      // '9'+1 .. 'A'
	localparam logic [RADIX_W-1:0] DEC_MAX     = 6'd9;

	typedef struct packed {
		logic                  done;
		logic [VALUE_BITS-1:0] quot;
		logic [RADIX_W-1:0]    rem;
	} div_res_t;

	// Clamp a written radix to 2..36.
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN)
			res = RADIX_MIN;
		else if (r > RADIX_MAX)
			res = RADIX_MAX;
		return res;
	endfunction

	// Digit value 0..35 to '0'..'9', 'A'..'Z'.
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		c = ASCII_ZERO + {1'b0, d};
		if (d > DEC_MAX)
			c = c + ALPHA_GAP;
		return c;
	endfunction

endpackage

/* hw/rtl/ira_divider.sv */
// ----------------------------------------------------------------------------
// ira_divider: iterative value / radix divider
// Restoring division, STEP_BITS quotient bits per cycle, narrow remainder.
// ----------------------------------------------------------------------------
module ira_divider import ira_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [RADIX_W-1:0]    radix,
	output div_res_t              res
);

	localparam logic [DIV_CNT_W-1:0] CYC_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

	logic [VALUE_BITS-1:0] dvd_q, dvd_n;   // dividend shifts out, quotient shifts in
	logic [RADIX_W-1:0]    rem_q, rem_n;
	logic [DIV_CNT_W-1:0]  cyc_q;
	logic                  busy_q;
	logic                  done_q;

	always_comb begin
		logic [RADIX_W:0] trial;
		trial = '0;
		dvd_n = dvd_q;
		rem_n = rem_q;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial = {rem_n, dvd_n[VALUE_BITS-1]};
			dvd_n = {dvd_n[VALUE_BITS-2:0], 1'b0};
			if (trial >= {1'b0, radix}) begin
				trial    = trial - {1'b0, radix};
				dvd_n[0] = 1'b1;
			end
			rem_n = trial[RADIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cyc_q  <= '0;
		end else begin
			done_q <= busy_q && (cyc_q == CYC_LAST) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cyc_q  <= '0;
			end else if (busy_q) begin
				cyc_q <= cyc_q + 1'b1;
				if (cyc_q == CYC_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
	end

	assign res.done = done_q;
	assign res.quot = dvd_q;
	assign res.rem  = rem_q;

endmodule

/* hw/rtl/integer_to_radix_ascii_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_unit: unsigned integer to ASCII digits in base 2..36
// Operation: divides the value by the radix again and again, one digit per
//   division, then one character per cycle while out_stall is low.
// Flow: a value yields 1..32 digits, all from the single shared 4-bit-per-cycle
//   divider; no new value is taken until the last digit of the previous one
//   has entered the output register; in_stall high while busy.
// Reset: async active low; idle, no output, radix back to 10.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_unit import ira_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	// result items
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  last,
	// radix register write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [RADIX_W-1:0]    cfg_data
);

	// Sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;   // ready for an item
	localparam logic [1:0] ST_DIV  = 2'd1;   // peeling digits, least significant first
	localparam logic [1:0] ST_EMIT = 2'd2;   // replaying digits most significant first

	logic [1:0]             state_q;
	logic [RADIX_W-1:0]     radix_q;         // already clamped to 2..36
	logic [DIGIT_CNT_W-1:0] cnt_q;           // digits found so far
	logic [DIGIT_CNT_W-1:0] pos_q;           // digits still to emit
	logic [RADIX_W-1:0]     digits_q [MAX_DIGITS];

	logic                   out_valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic                   in_accept;
	logic                   out_free;
	logic                   div_start;
	logic [VALUE_BITS-1:0]  div_operand;
	logic                   more_digits;
	logic [DIGIT_CNT_W-1:0] rd_pos;
	div_res_t               div_res;

	// Register port: always takes a write, value is clamped on the way in.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= RADIX_RESET;
		else if (cfg_valid && cfg_ready)
			radix_q <= clamp_radix(cfg_data);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Output register is free when empty or being taken this cycle.
	assign out_free  = !out_valid_q || !out_stall;

	// Divider restarts on the quotient until it reaches zero, so a zero
	// value still produces exactly one digit.
	assign more_digits = div_res.done && (div_res.quot != '0);
	assign div_start   = in_accept || (state_q == ST_DIV && more_digits);
	assign div_operand = in_accept ? value : div_res.quot;

	ira_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_operand),
		.radix    (radix_q),
		.res      (div_res)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						cnt_q <= cnt_q + 1'b1;
						if (!more_digits) begin
							state_q <= ST_EMIT;
							pos_q   <= cnt_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						pos_q <= pos_q - 1'b1;
						if (pos_q == DIGIT_CNT_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digit store, written in order of discovery
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_res.done)
			digits_q[cnt_q[DIGIT_IDX_W-1:0]] <= div_res.rem;
	end

	assign rd_pos = pos_q - 1'b1;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= (state_q == ST_EMIT);
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_EMIT) begin
			char_q <= digit_to_ascii(digits_q[rd_pos[DIGIT_IDX_W-1:0]]);
			last_q <= (pos_q == DIGIT_CNT_W'(1));
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last       = last_q;

	// Checks
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ST_DIV))
		else $error("accepted item did not start division");

	a_done_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV))
		else $error("divider result outside division phase");

	a_emit_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (pos_q != '0 && pos_q <= cnt_q))
		else $error("emit pointer out of range");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
			(digit_char >= 7'd65 && digit_char <= 7'd90)))
		else $error("digit character outside 0-9, A-Z");

endmodule
